// ===== sv/atoc_pkg.sv =====
// Package with shared types, constants and helpers of the ASCII calculator.
`timescale 1ns / 1ps
`default_nettype none
package atoc_pkg;

    localparam int LINE_BYTES_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_BITS      = 8;
    localparam int OUT_BITS       = 32;
    localparam int STATUS_BITS    = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DIV0   = 2'd2;

    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_PCT   = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    // Payload of one received transaction.
    typedef struct packed {
        logic [CHAR_BITS-1:0] rx_char;
    } rx_item_t;

    // Payload of one result transaction.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [OUT_BITS-1:0]    value;
    } res_item_t;

    // Parse phases of the character scanner.
    typedef enum logic [3:0] {
        PH_PRE1  = 4'd0,
        PH_SIGN1 = 4'd1,
        PH_DIG1  = 4'd2,
        PH_MID   = 4'd3,
        PH_PRE2  = 4'd4,
        PH_SIGN2 = 4'd5,
        PH_DIG2  = 4'd6,
        PH_TRAIL = 4'd7,
        PH_ERR   = 4'd8,
        PH_DONE  = 4'd9
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic feed;      // parse the held character
        logic clear;     // start a new line
        logic acc1;      // accumulate a digit into the first operand
        logic acc2;      // accumulate a digit into the second operand
        logic eval;      // start the evaluation of the line
        logic div_step;  // one restoring divide step
        logic finish;    // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // line is valid, the operator divides and the divisor is nonzero
        logic div_last;  // final divide step is running
    } dp_stat_t;

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// ===== sv/atoc_stream_if.sv =====
// Valid/ready stream interface used for both channels.
`timescale 1ns / 1ps
`default_nettype none
interface atoc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/atoc_datapath.sv =====
// Datapath: operand accumulation, parse phase, arithmetic and divider.
`timescale 1ns / 1ps
`default_nettype none
module atoc_datapath #(
    parameter int VALUE_BITS = atoc_pkg::VALUE_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire logic [atoc_pkg::CHAR_BITS-1:0]   char_in,
    input  wire atoc_pkg::dp_cmd_t                cmd,
    output atoc_pkg::dp_stat_t                    stat,
    output logic [atoc_pkg::STATUS_BITS-1:0]      status,
    output logic [atoc_pkg::OUT_BITS-1:0]         value
);
    import atoc_pkg::*;

    localparam int MAG_BITS  = VALUE_BITS + 1;
    localparam int WIDE_BITS = MAG_BITS + 4;
    localparam int CNT_BITS  = $clog2(VALUE_BITS);
    localparam logic [MAG_BITS-1:0] CAP = MAG_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

    phase_t                  phase_reg, phase_next;
    logic [MAG_BITS-1:0]     v1_reg, v2_reg;
    logic                    n1_reg, n2_reg;
    logic [CHAR_BITS-1:0]    op_reg;
    logic [VALUE_BITS-1:0]   quo_reg, rem_reg;
    logic [VALUE_BITS-1:0]   dvs_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [OUT_BITS-1:0]     value_reg;

    logic [MAG_BITS-1:0]     acc_src, acc_val;
    logic [WIDE_BITS-1:0]    acc_wide;
    logic [VALUE_BITS-1:0]   m1, m2, a_op, b_op;
    logic                    line_ok, is_div_op;
    logic [VALUE_BITS-1:0]   arith_res, div_res;
    logic [VALUE_BITS:0]     rem_shift, rem_sub;
    logic [STATUS_BITS-1:0]  fin_status;
    logic [VALUE_BITS-1:0]   fin_value;

    // Decimal accumulation with saturation at the top-bit magnitude.
    // The product times ten is built from two shifts and checked against the cap.
    assign acc_src = cmd.acc2 ? v2_reg : v1_reg;
    always_comb
    begin
        logic [WIDE_BITS-1:0] d;
        d        = WIDE_BITS'(char_in - CH_ZERO);
        acc_wide = (WIDE_BITS'(acc_src) << 3) + (WIDE_BITS'(acc_src) << 1) + d;
        if (acc_wide > WIDE_BITS'(CAP))
            acc_val = CAP;
        else
            acc_val = acc_wide[MAG_BITS-1:0];
    end

    // Next parse phase for the held character.
    always_comb
    begin
        phase_next = phase_reg;
        if (char_in == CH_NUL)
        begin
            phase_next = (phase_reg == PH_DIG2 || phase_reg == PH_TRAIL ||
                          phase_reg == PH_DONE) ? PH_DONE : PH_ERR;
        end
        else
        begin
            case (phase_reg)
                PH_PRE1, PH_PRE2:
                begin
                    if (is_blank(char_in))
                        phase_next = phase_reg;
                    else if (char_in == CH_PLUS || char_in == CH_MINUS)
                        phase_next = (phase_reg == PH_PRE2) ? PH_SIGN2 : PH_SIGN1;
                    else if (is_digit(char_in))
                        phase_next = (phase_reg == PH_PRE2) ? PH_DIG2 : PH_DIG1;
                    else
                        phase_next = PH_ERR;
                end
                PH_SIGN1: phase_next = is_digit(char_in) ? PH_DIG1 : PH_ERR;
                PH_SIGN2: phase_next = is_digit(char_in) ? PH_DIG2 : PH_ERR;
                PH_DIG1:
                begin
                    if (is_digit(char_in))
                        phase_next = PH_DIG1;
                    else if (is_blank(char_in))
                        phase_next = PH_MID;
                    else
                        phase_next = PH_PRE2;
                end
                PH_MID: phase_next = is_blank(char_in) ? PH_MID : PH_PRE2;
                PH_DIG2:
                begin
                    if (is_digit(char_in))
                        phase_next = PH_DIG2;
                    else
                        phase_next = is_blank(char_in) ? PH_TRAIL : PH_ERR;
                end
                PH_TRAIL: phase_next = is_blank(char_in) ? PH_TRAIL : PH_ERR;
                PH_DONE:  phase_next = PH_DONE;
                default:  phase_next = PH_ERR;
            endcase
        end
    end

    // Clamped magnitudes and two's complement operands.
    assign m1 = (v1_reg > (n1_reg ? CAP : CAP - 1'b1)) ?
                VALUE_BITS'(n1_reg ? CAP : CAP - 1'b1) : VALUE_BITS'(v1_reg);
    assign m2 = (v2_reg > (n2_reg ? CAP : CAP - 1'b1)) ?
                VALUE_BITS'(n2_reg ? CAP : CAP - 1'b1) : VALUE_BITS'(v2_reg);
    assign a_op = n1_reg ? VALUE_BITS'(0) - m1 : m1;
    assign b_op = n2_reg ? VALUE_BITS'(0) - m2 : m2;

    assign line_ok   = (phase_reg == PH_DIG2) || (phase_reg == PH_TRAIL) ||
                       (phase_reg == PH_DONE);
    assign is_div_op = (op_reg == CH_SLASH) || (op_reg == CH_PCT);
    assign stat.need_div = line_ok && is_div_op && (m2 != '0);
    assign stat.div_last = (cnt_reg == LAST_STEP);

    // One restoring divide step on magnitudes.
    assign rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // Final value selection.
    always_comb
    begin
        case (op_reg)
            CH_PLUS:  arith_res = a_op + b_op;
            CH_MINUS: arith_res = a_op - b_op;
            CH_STAR:  arith_res = VALUE_BITS'(a_op * b_op);
            default:  arith_res = '0;
        endcase
        if (op_reg == CH_SLASH)
            div_res = (n1_reg != n2_reg) ? VALUE_BITS'(0) - quo_reg : quo_reg;
        else
            div_res = n1_reg ? VALUE_BITS'(0) - rem_reg : rem_reg;
        fin_status = ST_INVALID;
        fin_value  = '0;
        if (line_ok)
        begin
            if (op_reg == CH_PLUS || op_reg == CH_MINUS || op_reg == CH_STAR)
            begin
                fin_status = ST_OK;
                fin_value  = arith_res;
            end
            else if (is_div_op)
            begin
                if (m2 == '0)
                    fin_status = ST_DIV0;
                else
                begin
                    fin_status = ST_OK;
                    fin_value  = div_res;
                end
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE1;
            v1_reg    <= '0;
            v2_reg    <= '0;
            n1_reg    <= 1'b0;
            n2_reg    <= 1'b0;
            op_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            phase_reg <= PH_PRE1;
            v1_reg    <= '0;
            v2_reg    <= '0;
            n1_reg    <= 1'b0;
            n2_reg    <= 1'b0;
            op_reg    <= '0;
        end
        else if (cmd.feed)
        begin
            phase_reg <= phase_next;
            if (cmd.acc1)
                v1_reg <= acc_val;
            if (cmd.acc2)
                v2_reg <= acc_val;
            if (char_in != CH_NUL)
            begin
                if (phase_reg == PH_PRE1 && (char_in == CH_PLUS || char_in == CH_MINUS))
                    n1_reg <= (char_in == CH_MINUS);
                if (phase_reg == PH_PRE2 && (char_in == CH_PLUS || char_in == CH_MINUS))
                    n2_reg <= (char_in == CH_MINUS);
                if ((phase_reg == PH_DIG1 && !is_digit(char_in) && !is_blank(char_in)) ||
                    (phase_reg == PH_MID && !is_blank(char_in)))
                    op_reg <= char_in;
            end
        end
    end

    // Divider registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.eval)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            quo_reg <= m1;
            rem_reg <= '0;
            dvs_reg <= m2;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[VALUE_BITS])
            begin
                rem_reg <= rem_sub[VALUE_BITS-1:0];
                quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[VALUE_BITS-1:0];
                quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= fin_status;
            value_reg  <= OUT_BITS'($signed(fin_value));
        end
    end

    assign status = status_reg;
    assign value  = value_reg;

endmodule
`default_nettype wire

// ===== sv/atoc_control.sv =====
// Controller: input handshake, line counting and evaluation sequencing.
`timescale 1ns / 1ps
`default_nettype none
module atoc_control #(
    parameter int LINE_BYTES = atoc_pkg::LINE_BYTES_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire logic [atoc_pkg::CHAR_BITS-1:0] in_char,
    output logic [atoc_pkg::CHAR_BITS-1:0]      char_out,
    output logic                                out_valid,
    input  wire                                 out_ready,
    input  wire atoc_pkg::dp_stat_t             stat,
    output atoc_pkg::dp_cmd_t                   cmd
);
    import atoc_pkg::*;

    localparam int LC_BITS = $clog2(LINE_BYTES);
    localparam logic [LC_BITS-1:0] LC_MAX = LC_BITS'(LINE_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_EVAL,
        S_DIV,
        S_FIN
    } state_t;

    state_t               state_reg;
    logic [LC_BITS-1:0]   lc_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 out_valid_reg;
    logic                 in_fire, is_eol;
    logic                 dp_acc1, dp_acc2;
    phase_t               ph_reg;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign is_eol   = (in_char == CH_LF) || (in_char == CH_CR);

    // Commands decoded from state and the held character.
    always_comb
    begin
        cmd          = '0;
        cmd.feed     = (state_reg == S_FEED);
        cmd.acc1     = cmd.feed && is_digit(char_reg) && dp_acc1;
        cmd.acc2     = cmd.feed && is_digit(char_reg) && dp_acc2;
        cmd.eval     = (state_reg == S_EVAL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.finish   = (state_reg == S_FIN);
        cmd.clear    = (state_reg == S_FIN);
    end

    // Digits go to the operand that the shadow phase points at.
    always_comb
    begin
        dp_acc1 = (ph_reg == PH_PRE1) || (ph_reg == PH_SIGN1) || (ph_reg == PH_DIG1);
        dp_acc2 = (ph_reg == PH_PRE2) || (ph_reg == PH_SIGN2) || (ph_reg == PH_DIG2);
        if (char_reg == CH_NUL)
        begin
            dp_acc1 = 1'b0;
            dp_acc2 = 1'b0;
        end
    end

    // Shadow of the parse phase, kept coarse for digit routing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= PH_PRE1;
        else if (cmd.clear)
            ph_reg <= PH_PRE1;
        else if (cmd.feed)
        begin
            if (char_reg == CH_NUL)
                ph_reg <= PH_ERR;
            else
            begin
                case (ph_reg)
                    PH_PRE1:
                        if (char_reg == CH_PLUS || char_reg == CH_MINUS)
                            ph_reg <= PH_SIGN1;
                        else if (is_digit(char_reg))
                            ph_reg <= PH_DIG1;
                        else if (!is_blank(char_reg))
                            ph_reg <= PH_ERR;
                    PH_SIGN1: ph_reg <= is_digit(char_reg) ? PH_DIG1 : PH_ERR;
                    PH_DIG1:
                        if (!is_digit(char_reg))
                            ph_reg <= is_blank(char_reg) ? PH_MID : PH_PRE2;
                    PH_MID:
                        if (!is_blank(char_reg))
                            ph_reg <= PH_PRE2;
                    PH_PRE2:
                        if (char_reg == CH_PLUS || char_reg == CH_MINUS)
                            ph_reg <= PH_SIGN2;
                        else if (is_digit(char_reg))
                            ph_reg <= PH_DIG2;
                        else if (!is_blank(char_reg))
                            ph_reg <= PH_ERR;
                    PH_SIGN2: ph_reg <= is_digit(char_reg) ? PH_DIG2 : PH_ERR;
                    PH_DIG2:
                        if (!is_digit(char_reg))
                            ph_reg <= PH_ERR;
                    default: ph_reg <= PH_ERR;
                endcase
            end
        end
    end

    // Sequencer with registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        if (is_eol)
                        begin
                            if (lc_reg != '0)
                                state_reg <= S_EVAL;
                        end
                        else if (lc_reg < LC_MAX)
                        begin
                            lc_reg    <= lc_reg + 1'b1;
                            state_reg <= S_FEED;
                        end
                    end
                S_FEED: state_reg <= S_IDLE;
                S_EVAL: state_reg <= stat.need_div ? S_DIV : S_FIN;
                S_DIV:
                    if (stat.div_last)
                        state_reg <= S_FIN;
                S_FIN:
                begin
                    lc_reg        <= '0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            char_reg <= in_char;
    end

    assign char_out  = char_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== sv/ascii_two_operand_calculator.sv =====
// Top level of the ASCII two-operand calculator.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------
//  rx       | in        | rx_char [7:0]
//  res      | out       | status [1:0], value [31:0] signed
//
// A kept byte is accepted in S_IDLE and parsed in S_FEED. A dropped byte past
// the line limit or an empty line end is consumed in S_IDLE alone. A nonempty
// line end passes through S_EVAL to S_FIN, which raises the registered result
// valid; for / and % on a valid line with a nonzero divisor, S_DIV runs between
// them, a restoring divider that gives one quotient bit per cycle. No byte is
// accepted while the result waits. Reset is asynchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module ascii_two_operand_calculator #(
    parameter int LINE_BYTES = atoc_pkg::LINE_BYTES_DEF,
    parameter int VALUE_BITS = atoc_pkg::VALUE_BITS_DEF
) (
    input wire           clk,
    input wire           rst_n,
    atoc_stream_if.sink  rx,
    atoc_stream_if.source res
);
    import atoc_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [CHAR_BITS-1:0] char_held;
    logic [STATUS_BITS-1:0] st;
    logic [OUT_BITS-1:0]  val;

    atoc_control #(.LINE_BYTES(LINE_BYTES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_char   (rx.data.rx_char),
        .char_out  (char_held),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    atoc_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_held),
        .cmd     (cmd),
        .stat    (stat),
        .status  (st),
        .value   (val)
    );

    assign res.data.status = st;
    assign res.data.value  = val;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ASCII two-operand calculator.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: tracks the line parse and holds the results still to come back.
class calc_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } line_result_t;

    atoc_pkg::phase_t phase;
    logic [63:0]      mag_a;
    logic [63:0]      mag_b;
    logic             neg_a;
    logic             neg_b;
    logic [7:0]       op_byte;
    int unsigned      kept_bytes;
    line_result_t     pending[$];
    int unsigned      error_count;
    int unsigned      lines_checked;
    int unsigned      ok_lines;
    int unsigned      bad_lines;
    int unsigned      div0_lines;

    function new();
        clear_line();
        error_count   = 0;
        lines_checked = 0;
        ok_lines      = 0;
        bad_lines     = 0;
        div0_lines    = 0;
    endfunction

    function void clear_line();
        phase      = atoc_pkg::PH_PRE1;
        mag_a      = '0;
        mag_b      = '0;
        neg_a      = 1'b0;
        neg_b      = 1'b0;
        op_byte    = '0;
        kept_bytes = 0;
    endfunction

    function bit blank_char(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function bit digit_char(logic [7:0] c);
        return c >= atoc_pkg::CH_ZERO && c <= atoc_pkg::CH_NINE;
    endfunction

    // Decimal accumulation that saturates at 2^31.
    function logic [63:0] add_digit(logic [63:0] m, logic [7:0] c);
        logic [63:0] cap;
        logic [63:0] d;
        cap = 64'd1 << 31;
        d   = 64'(c - atoc_pkg::CH_ZERO);
        if (m > (cap - d) / 10)
            return cap;
        return m * 10 + d;
    endfunction

    function bit operand_done(atoc_pkg::phase_t p);
        return p == atoc_pkg::PH_DIG2 || p == atoc_pkg::PH_TRAIL || p == atoc_pkg::PH_DONE;
    endfunction

    // One kept byte of a line moves the parse along.
    function void parse_byte(logic [7:0] c);
        if (c == atoc_pkg::CH_NUL) begin
            phase = operand_done(phase) ? atoc_pkg::PH_DONE : atoc_pkg::PH_ERR;
            return;
        end
        case (phase)
            atoc_pkg::PH_PRE1, atoc_pkg::PH_PRE2:
            begin
                if (blank_char(c))
                    return;
                if (c == atoc_pkg::CH_PLUS || c == atoc_pkg::CH_MINUS) begin
                    if (phase == atoc_pkg::PH_PRE2)
                    begin
                        neg_b = (c == atoc_pkg::CH_MINUS);
                        phase = atoc_pkg::PH_SIGN2;
                    end
                    else
                    begin
                        neg_a = (c == atoc_pkg::CH_MINUS);
                        phase = atoc_pkg::PH_SIGN1;
                    end
                end
                else if (digit_char(c))
                begin
                    if (phase == atoc_pkg::PH_PRE2)
                    begin
                        mag_b = add_digit(mag_b, c);
                        phase = atoc_pkg::PH_DIG2;
                    end
                    else
                    begin
                        mag_a = add_digit(mag_a, c);
                        phase = atoc_pkg::PH_DIG1;
                    end
                end
                else
                    phase = atoc_pkg::PH_ERR;
            end
            atoc_pkg::PH_SIGN1:
            begin
                if (digit_char(c))
                begin
                    mag_a = add_digit(mag_a, c);
                    phase = atoc_pkg::PH_DIG1;
                end
                else
                    phase = atoc_pkg::PH_ERR;
            end
            atoc_pkg::PH_SIGN2:
            begin
                if (digit_char(c))
                begin
                    mag_b = add_digit(mag_b, c);
                    phase = atoc_pkg::PH_DIG2;
                end
                else
                    phase = atoc_pkg::PH_ERR;
            end
            atoc_pkg::PH_DIG1:
            begin
                if (digit_char(c))
                    mag_a = add_digit(mag_a, c);
                else if (blank_char(c))
                    phase = atoc_pkg::PH_MID;
                else
                begin
                    op_byte = c;
                    phase   = atoc_pkg::PH_PRE2;
                end
            end
            atoc_pkg::PH_MID:
            begin
                if (!blank_char(c))
                begin
                    op_byte = c;
                    phase   = atoc_pkg::PH_PRE2;
                end
            end
            atoc_pkg::PH_DIG2:
            begin
                if (digit_char(c))
                    mag_b = add_digit(mag_b, c);
                else
                    phase = blank_char(c) ? atoc_pkg::PH_TRAIL : atoc_pkg::PH_ERR;
            end
            atoc_pkg::PH_TRAIL:
            begin
                if (!blank_char(c))
                    phase = atoc_pkg::PH_ERR;
            end
            atoc_pkg::PH_DONE:
            begin
            end
            default:
                phase = atoc_pkg::PH_ERR;
        endcase
    endfunction

    // Evaluate the finished line into a status and a 32-bit value.
    function line_result_t evaluate_line();
        line_result_t r;
        logic [63:0]  m1;
        logic [63:0]  m2;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  q;
        m1 = (mag_a > (neg_a ? 64'h8000_0000 : 64'h7FFF_FFFF)) ?
             (neg_a ? 64'h8000_0000 : 64'h7FFF_FFFF) : mag_a;
        m2 = (mag_b > (neg_b ? 64'h8000_0000 : 64'h7FFF_FFFF)) ?
             (neg_b ? 64'h8000_0000 : 64'h7FFF_FFFF) : mag_b;
        a  = neg_a ? -m1[31:0] : m1[31:0];
        b  = neg_b ? -m2[31:0] : m2[31:0];
        r.status = atoc_pkg::ST_INVALID;
        r.value  = '0;
        if (!operand_done(phase))
            return r;
        case (op_byte)
            atoc_pkg::CH_PLUS:  r.value = a + b;
            atoc_pkg::CH_MINUS: r.value = a - b;
            atoc_pkg::CH_STAR:  r.value = a * b;
            atoc_pkg::CH_SLASH, atoc_pkg::CH_PCT:
            begin
                if (m2 == 0)
                begin
                    r.status = atoc_pkg::ST_DIV0;
                    return r;
                end
                if (op_byte == atoc_pkg::CH_SLASH)
                begin
                    q       = 32'(m1 / m2);
                    r.value = (neg_a != neg_b) ? -q : q;
                end
                else
                begin
                    q       = 32'(m1 % m2);
                    r.value = neg_a ? -q : q;
                end
            end
            default:
                return r;
        endcase
        r.status = atoc_pkg::ST_OK;
        return r;
    endfunction

    // Note one accepted received byte.
    function void note_byte(logic [7:0] c);
        if (c == atoc_pkg::CH_LF || c == atoc_pkg::CH_CR)
        begin
            if (kept_bytes != 0)
                pending.push_back(evaluate_line());
            clear_line();
        end
        else if (kept_bytes < 31)
        begin
            kept_bytes++;
            parse_byte(c);
        end
    endfunction

    // Compare one returned transaction with the oldest expectation.
    function void check_result(logic [1:0] status, logic [31:0] value);
        line_result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d value=%0d", $time, status,
                     $signed(value));
            error_count++;
            return;
        end
        e = pending.pop_front();
        lines_checked++;
        case (e.status)
            atoc_pkg::ST_OK:      ok_lines++;
            atoc_pkg::ST_DIV0:    div0_lines++;
            default:              bad_lines++;
        endcase
        if (status !== e.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
            error_count++;
        end
        if (value !== e.value)
        begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     $signed(e.value), $signed(value));
            error_count++;
        end
    endfunction
endclass

module testbench;
    localparam int ITEM_TARGET = 1250;
    localparam int CYCLE_LIMIT = 2000000;

    logic           clk;
    logic           rst_n;
    calc_scoreboard scoreboard;
    int unsigned    bytes_sent;
    int unsigned    cycle_count;
    bit             no_idling;

    atoc_stream_if #(.payload_t(atoc_pkg::rx_item_t))  rx ();
    atoc_stream_if #(.payload_t(atoc_pkg::res_item_t)) res ();

    ascii_two_operand_calculator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Timeout watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("ascii_two_operand_calculator regression: fail");
                $finish;
            end
        end
    end

    // Result side: random stall bursts on ready, checking every transaction.
    initial
    begin
        int stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!no_idling && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 6);
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            if (res.valid && res.ready)
                scoreboard.check_result(res.data.status, res.data.value);
        end
    end

    // Send one byte, with an optional idle burst ahead of it.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (!no_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid        <= 1'b1;
        rx.data.rx_char <= c;
        do
            @(posedge clk);
        while (!rx.ready);
        scoreboard.note_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Hold off until every expected line result has come back.
    task automatic drain();
        rx.valid <= 1'b0;
        while (scoreboard.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic byte random_blank();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic byte random_op();
        case ($urandom_range(0, 4))
            0: return atoc_pkg::CH_PLUS;
            1: return atoc_pkg::CH_MINUS;
            2: return atoc_pkg::CH_STAR;
            3: return atoc_pkg::CH_SLASH;
            default: return atoc_pkg::CH_PCT;
        endcase
    endfunction

    // Random operand text: mostly short, sometimes long enough to saturate.
    function automatic string random_operand();
        string s;
        int    n;
        s = "";
        case ($urandom_range(0, 5))
            0: s = "+";
            1, 2: s = "-";
            default: s = "";
        endcase
        case ($urandom_range(0, 9))
            0: return {s, "2147483648"};
            1: return {s, "2147483647"};
            2: return {s, "0"};
            3: n = $urandom_range(10, 14);
            default: n = $urandom_range(1, 4);
        endcase
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string random_blanks(input int max_n);
        string s;
        s = "";
        repeat ($urandom_range(0, max_n))
            s = {s, string'(random_blank())};
        return s;
    endfunction

    // One random line: mostly well formed, the rest noise or damaged text.
    task automatic send_random_line();
        string line;
        string tail;
        bit    with_nul;
        int    kind;
        int    pos;
        tail     = "";
        with_nul = 1'b0;
        kind = $urandom_range(0, 19);
        if (kind < 13)
            line = {random_blanks(2), random_operand(), random_blanks(2), string'(random_op()),
                    random_blanks(2), random_operand(), random_blanks(2)};
        else if (kind < 15)
        begin
            line = "";
            repeat ($urandom_range(1, 12))
                line = {line, string'(byte'($urandom_range(0, 255)))};
        end
        else if (kind == 15)
            line = {random_operand(), random_blanks(3), string'(random_op()), random_operand(),
                    "          ", "          ", string'(random_op()), "9"};
        else if (kind == 16)
        begin
            // The expression ends at a NUL byte; the rest of the line is ignored.
            line     = {random_operand(), string'(random_op()), random_operand()};
            tail     = "?x";
            with_nul = 1'b1;
        end
        else
        begin
            // Damage a well-formed line at one random place.
            line = {random_operand(), " ", string'(random_op()), " ", random_operand()};
            pos  = $urandom_range(0, line.len() - 1);
            line[pos] = byte'($urandom_range(0, 255));
        end
        for (int i = 0; i < line.len(); i++)
            if (line[i] == 8'h0A || line[i] == 8'h0D)
                line[i] = 8'h41;
        send_text(line);
        if (with_nul)
        begin
            send_byte(atoc_pkg::CH_NUL);
            send_text(tail);
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(atoc_pkg::CH_LF);
        send_byte($urandom_range(0, 1) ? atoc_pkg::CH_LF : atoc_pkg::CH_CR);
    endtask

    initial
    begin
        scoreboard = new();
        bytes_sent = 0;
        no_idling  = 1'b0;
        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.data    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: extremes, every operator and the parse corner cases.
        send_text("0+0\n2147483647+1\r-2147483648-1\n");
        send_text("-2147483648/-1\n-2147483648%-1\n7/0\n7%0\n");
        send_text("-7/2\n-7%2\n3*-4\n \t12 - +5 \x0b\x0c\n");
        send_text("5 3\n+ 5+1\n");
        send_byte(atoc_pkg::CH_NUL);
        send_text("\n1+2");
        send_byte(atoc_pkg::CH_NUL);
        send_text("xyz\n");
        send_text("99999999999*99999999999\n\n\r5x6\n-\n1+\n");
        send_text("1+1                                 garbage\n");
        drain();

        // Random lines, pausing in full before any line that starts just past halfway.
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent > ITEM_TARGET / 2 && bytes_sent < ITEM_TARGET / 2 + 20)
                drain();
            if (bytes_sent > ITEM_TARGET - 150)
                no_idling = 1'b1;
            send_random_line();
        end
        rx.valid <= 1'b0;

        // Let the last results drain.
        while (scoreboard.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d bytes; checked %0d lines: %0d ok, %0d invalid, %0d divide by zero",
                 bytes_sent, scoreboard.lines_checked, scoreboard.ok_lines,
                 scoreboard.bad_lines, scoreboard.div0_lines);
        if (scoreboard.error_count == 0 && scoreboard.pending.size() == 0)
            $display("ascii_two_operand_calculator regression: pass");
        else
            $display("ascii_two_operand_calculator regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
